// File: rtl/ebvs_pkg.sv
// ----------------------------------------------------------------------------
// ebvs_pkg: expert buffer victim select shared definitions
// Status codes, flag bit positions and default sizing for the victim selector.
// ----------------------------------------------------------------------------
`default_nettype none

package ebvs_pkg;

    // Default interface version after reset
    localparam logic [31:0] EB_VERSION_DEFAULT = 32'd1;

    // Flag bit positions in entry_flags
    localparam int EB_RES_BIT  = 0;
    localparam int EB_ELIG_BIT = 1;

    // Default number of slots in one batch
    localparam int EB_MAX_ENTRIES = 64;

    // Field widths fixed by the interface
    localparam int EB_FLAGS_W    = 8;
    localparam int EB_STAMP_W    = 64;
    localparam int EB_TOKEN_W    = 32;
    localparam int EB_CAP_W      = 7;
    localparam int EB_INCOMING_W = 6;
    localparam int EB_EPOCH_W    = 64;
    localparam int EB_VERSION_W  = 32;
    localparam int EB_STATUS_W   = 3;
    localparam int EB_VICTIM_W   = 6;

    typedef enum logic [EB_STATUS_W-1:0] {
        ST_INVALID = 3'd0,
        ST_HIT     = 3'd1,
        ST_ADMIT   = 3'd2,
        ST_EVICT   = 3'd3,
        ST_BLOCKED = 3'd4
    } status_t;

endpackage

`default_nettype wire

// File: rtl/expert_buffer_victim_select.sv
// ----------------------------------------------------------------------------
// expert_buffer_victim_select: pick an eviction victim for an expert buffer
// Scans a batch of expert-slot entries and issues one admission decision.
// ----------------------------------------------------------------------------
//
// Usage:
//   Entries of a batch arrive on the input channel (in_valid / in_ready), one
//   request per entry, in slot order from 0; is_last marks the final entry.
//   capacity, incoming, request_epoch and batch_version are sampled from the
//   first entry of each batch only. The final entry produces one decision on
//   the output channel (out_valid / out_ready); other entries produce none.
//   cfg_wr_en / cfg_wr_data write expected_version in one cycle, while idle.
// Timing:
//   One entry per cycle sustained while no final entry waits on a held
//   decision. An accepted request sits in the input register while the scan
//   state updates; for the final entry the decision is loaded into the
//   result register at that same edge. The rate is set by the update of the
//   scan state (one 64-bit stamp compare).
// Reset:
//   rst_n clears the scan state, empties both registers and sets
//   expected_version back to 1.
// Stall:
//   A held decision waits in the result register; non-final entries keep
//   flowing, and a final entry waits in the input register until the result
//   register frees up.
//
`default_nettype none

module expert_buffer_victim_select #(
    parameter int MAX_ENTRIES = ebvs_pkg::EB_MAX_ENTRIES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_wr_en,
    input  wire logic [ebvs_pkg::EB_VERSION_W-1:0] cfg_wr_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [ebvs_pkg::EB_FLAGS_W-1:0]   entry_flags,
    input  wire logic [ebvs_pkg::EB_STAMP_W-1:0]   admission_stamp,
    input  wire logic [ebvs_pkg::EB_TOKEN_W-1:0]   tokens_routed,
    input  wire logic                              is_last,
    input  wire logic [ebvs_pkg::EB_CAP_W-1:0]     capacity,
    input  wire logic [ebvs_pkg::EB_INCOMING_W-1:0] incoming,
    input  wire logic [ebvs_pkg::EB_EPOCH_W-1:0]   request_epoch,
    input  wire logic [ebvs_pkg::EB_VERSION_W-1:0] batch_version,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ebvs_pkg::EB_STATUS_W-1:0]       status,
    output logic [ebvs_pkg::EB_VICTIM_W-1:0]       victim,
    output logic                                   victim_valid,
    output logic [ebvs_pkg::EB_EPOCH_W-1:0]        epoch_echo
);

    import ebvs_pkg::*;

    // Counter holds 0..MAX_ENTRIES, index holds 0..MAX_ENTRIES-1
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CMP_W = (CNT_W > EB_CAP_W) ? CNT_W : EB_CAP_W;
    localparam int VIC_W = (IDX_W > EB_VICTIM_W) ? IDX_W : EB_VICTIM_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // Configuration
    logic [EB_VERSION_W-1:0]  expected_version_reg;

    // Input register
    logic                     s1_valid_reg;
    logic [EB_FLAGS_W-1:0]    s1_flags_reg;
    logic [EB_STAMP_W-1:0]    s1_stamp_reg;
    logic                     s1_active_reg;
    logic                     s1_last_reg;
    logic [EB_CAP_W-1:0]      s1_capacity_reg;
    logic [EB_INCOMING_W-1:0] s1_incoming_reg;
    logic [EB_EPOCH_W-1:0]    s1_epoch_reg;
    logic [EB_VERSION_W-1:0]  s1_version_reg;

    // Scan state
    logic [CNT_W-1:0]         entry_index_reg,       entry_index_next;
    logic [CNT_W-1:0]         resident_count_reg,    resident_count_next;
    logic [IDX_W-1:0]         best_index_reg,        best_index_next;
    logic                     best_found_reg,        best_found_next;
    logic                     best_active_reg,       best_active_next;
    logic [EB_STAMP_W-1:0]    best_stamp_reg,        best_stamp_next;
    logic                     error_seen_reg,        error_seen_next;
    logic [EB_CAP_W-1:0]      held_capacity_reg,     held_capacity_next;
    logic [EB_INCOMING_W-1:0] held_incoming_reg,     held_incoming_next;
    logic [EB_EPOCH_W-1:0]    held_epoch_reg,        held_epoch_next;
    logic                     incoming_resident_reg, incoming_resident_next;
    logic                     incoming_active_reg,   incoming_active_next;

    // Result register
    logic                     out_valid_reg;
    status_t                  status_reg,            status_next;
    logic [EB_VICTIM_W-1:0]   victim_reg,            victim_next;
    logic                     victim_valid_reg,      victim_valid_next;
    logic [EB_EPOCH_W-1:0]    epoch_echo_reg;

    logic                     s1_adv;
    logic                     first;
    logic                     flag_res;
    logic                     flag_elig;
    logic                     flag_unknown;
    logic                     in_range;
    logic                     take_best;
    logic [VIC_W-1:0]         best_wide;

    // Advance the held entry; a final entry also needs room for its decision
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    assign first        = (entry_index_reg == '0);
    assign flag_res     = s1_flags_reg[EB_RES_BIT];
    assign flag_elig    = s1_flags_reg[EB_ELIG_BIT];
    assign flag_unknown = |s1_flags_reg[EB_FLAGS_W-1:2];
    assign in_range     = (entry_index_reg < MAX_CNT);

    // Idle beats active; within a class the later stamp wins; ties keep older
    assign take_best = !best_found_reg
                    || (!s1_active_reg && best_active_reg)
                    || ((s1_active_reg == best_active_reg)
                        && (s1_stamp_reg > best_stamp_reg));

    always_comb
    begin
        entry_index_next       = entry_index_reg;
        resident_count_next    = resident_count_reg;
        best_index_next        = best_index_reg;
        best_found_next        = best_found_reg;
        best_active_next       = best_active_reg;
        best_stamp_next        = best_stamp_reg;
        error_seen_next        = error_seen_reg;
        held_capacity_next     = held_capacity_reg;
        held_incoming_next     = held_incoming_reg;
        held_epoch_next        = held_epoch_reg;
        incoming_resident_next = incoming_resident_reg;
        incoming_active_next   = incoming_active_reg;

        // Sample the request on the first entry of the batch
        if (first)
        begin
            held_capacity_next = s1_capacity_reg;
            held_incoming_next = s1_incoming_reg;
            held_epoch_next    = s1_epoch_reg;
            if ((s1_version_reg != expected_version_reg) || (s1_capacity_reg == '0)
                || (s1_epoch_reg == '0))
            begin
                error_seen_next = 1'b1;
            end
        end

        if (!in_range)
        begin
            error_seen_next = 1'b1;
        end
        else
        begin
            priority if (flag_unknown)
            begin
                error_seen_next = 1'b1;
            end
            else if (!flag_res)
            begin
                if ((s1_flags_reg != '0) || (s1_stamp_reg != '0))
                    error_seen_next = 1'b1;
            end
            else
            begin
                if (s1_stamp_reg == '0)
                    error_seen_next = 1'b1;
                resident_count_next = resident_count_reg + CNT_W'(1);
                if (flag_elig && take_best)
                begin
                    best_index_next  = entry_index_reg[IDX_W-1:0];
                    best_active_next = s1_active_reg;
                    best_stamp_next  = s1_stamp_reg;
                    best_found_next  = 1'b1;
                end
            end
            if (CMP_W'(entry_index_reg) == CMP_W'(held_incoming_next))
            begin
                incoming_resident_next = flag_res;
                incoming_active_next   = s1_active_reg;
            end
            entry_index_next = entry_index_reg + CNT_W'(1);
        end

        // Batch-level checks on the final entry
        if (s1_last_reg)
        begin
            if ((CMP_W'(held_capacity_next) > CMP_W'(entry_index_next))
                || (CMP_W'(held_incoming_next) >= CMP_W'(entry_index_next))
                || (CMP_W'(resident_count_next) > CMP_W'(held_capacity_next))
                || !incoming_active_next)
            begin
                error_seen_next = 1'b1;
            end
        end
    end

    // Decision from the updated scan state
    assign best_wide = VIC_W'(best_index_next);

    always_comb
    begin
        status_next       = ST_INVALID;
        victim_next       = '0;
        victim_valid_next = 1'b0;
        if (!error_seen_next)
        begin
            priority if (incoming_resident_next)
            begin
                status_next = ST_HIT;
            end
            else if (CMP_W'(resident_count_next) < CMP_W'(held_capacity_next))
            begin
                status_next = ST_ADMIT;
            end
            else if (best_found_next)
            begin
                status_next       = ST_EVICT;
                victim_next       = best_wide[EB_VICTIM_W-1:0];
                victim_valid_next = 1'b1;
            end
            else
            begin
                status_next = ST_BLOCKED;
            end
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_version_reg <= EB_VERSION_DEFAULT;
        else if (cfg_wr_en)
            expected_version_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_flags_reg    <= entry_flags;
            s1_stamp_reg    <= admission_stamp;
            s1_active_reg   <= (tokens_routed != '0);
            s1_last_reg     <= is_last;
            s1_capacity_reg <= capacity;
            s1_incoming_reg <= incoming;
            s1_epoch_reg    <= request_epoch;
            s1_version_reg  <= batch_version;
        end
    end

    // Scan state: advance per entry, clear after the final entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_index_reg       <= '0;
            resident_count_reg    <= '0;
            best_index_reg        <= '0;
            best_found_reg        <= 1'b0;
            best_active_reg       <= 1'b1;
            best_stamp_reg        <= '0;
            error_seen_reg        <= 1'b0;
            held_capacity_reg     <= '0;
            held_incoming_reg     <= '0;
            held_epoch_reg        <= '0;
            incoming_resident_reg <= 1'b0;
            incoming_active_reg   <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            entry_index_reg       <= '0;
            resident_count_reg    <= '0;
            best_index_reg        <= '0;
            best_found_reg        <= 1'b0;
            best_active_reg       <= 1'b1;
            best_stamp_reg        <= '0;
            error_seen_reg        <= 1'b0;
            held_capacity_reg     <= '0;
            held_incoming_reg     <= '0;
            held_epoch_reg        <= '0;
            incoming_resident_reg <= 1'b0;
            incoming_active_reg   <= 1'b0;
        end
        else if (s1_adv)
        begin
            entry_index_reg       <= entry_index_next;
            resident_count_reg    <= resident_count_next;
            best_index_reg        <= best_index_next;
            best_found_reg        <= best_found_next;
            best_active_reg       <= best_active_next;
            best_stamp_reg        <= best_stamp_next;
            error_seen_reg        <= error_seen_next;
            held_capacity_reg     <= held_capacity_next;
            held_incoming_reg     <= held_incoming_next;
            held_epoch_reg        <= held_epoch_next;
            incoming_resident_reg <= incoming_resident_next;
            incoming_active_reg   <= incoming_active_next;
        end
    end

    // Result register: load on the final entry, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            status_reg       <= status_next;
            victim_reg       <= victim_next;
            victim_valid_reg <= victim_valid_next;
            epoch_echo_reg   <= held_epoch_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign victim       = victim_reg;
    assign victim_valid = victim_valid_reg;
    assign epoch_echo   = epoch_echo_reg;

`ifndef SYNTHESIS
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_index_reg <= MAX_CNT)
        else $error("entry index beyond batch limit");

    a_resident_bound: assert property (@(posedge clk) disable iff (!rst_n)
        resident_count_reg <= entry_index_reg)
        else $error("resident count exceeds entries seen");

    a_best_seen: assert property (@(posedge clk) disable iff (!rst_n)
        best_found_reg |-> (CNT_W'(best_index_reg) < entry_index_reg))
        else $error("victim candidate not among entries seen");

    a_victim_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (victim_valid_reg == (status_reg == ST_EVICT)))
        else $error("victim_valid disagrees with status");

    a_final_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> (out_valid_reg && (entry_index_reg == '0)))
        else $error("final entry did not produce a decision and clear the scan");
`endif

endmodule

`default_nettype wire

// File: sim/tb_expert_buffer_victim_select.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_expert_buffer_victim_select: self-checking bench for the victim selector
// Streams batches of expert-slot entries into the block and keeps a cycle-free
// model of the scan state next to it. Each decision that leaves the block is
// checked against the model's prediction. Directed batches cover every
// decision and every fault but an oversized batch. Random batches follow,
// mostly well formed with injected faults mixed in. They run under several
// expected_version settings, with bursts of backpressure on both channels,
// and end in a stretch with no idling.
// ----------------------------------------------------------------------------

module tb_expert_buffer_victim_select;
    import ebvs_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int SLOTS        = EB_MAX_ENTRIES;
    localparam logic [EB_FLAGS_W-1:0] FLAG_RES   = 8'd1 << EB_RES_BIT;
    localparam logic [EB_FLAGS_W-1:0] FLAG_ELIG  = 8'd1 << EB_ELIG_BIT;
    localparam logic [EB_FLAGS_W-1:0] FLAG_KNOWN = FLAG_RES | FLAG_ELIG;

    // Fault kinds injected into otherwise clean random batches
    localparam int FLT_VERSION   = 0;
    localparam int FLT_EPOCH     = 1;
    localparam int FLT_ZERO_CAP  = 2;
    localparam int FLT_BIG_CAP   = 3;
    localparam int FLT_INCOMING  = 4;
    localparam int FLT_BAD_FLAG  = 5;
    localparam int FLT_NONRES    = 6;
    localparam int FLT_NO_STAMP  = 7;
    localparam int FLT_OVERFULL  = 8;
    localparam int FLT_IDLE_INC  = 9;
    localparam int FLT_OVERSIZE  = 10;
    localparam int FLT_GARBAGE   = 11;

    // One entry as it travels on the input channel
    typedef struct {
        logic [EB_FLAGS_W-1:0]    flags;
        logic [EB_STAMP_W-1:0]    stamp;
        logic [EB_TOKEN_W-1:0]    tokens;
        logic                     last;
        logic [EB_CAP_W-1:0]      cap;
        logic [EB_INCOMING_W-1:0] inc;
        logic [EB_EPOCH_W-1:0]    epoch;
        logic [EB_VERSION_W-1:0]  version;
    } slot_req_t;

    // One admission decision
    typedef struct {
        status_t                  status;
        logic [EB_VICTIM_W-1:0]   victim;
        logic                     victim_valid;
        logic [EB_EPOCH_W-1:0]    epoch;
    } decision_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [EB_VERSION_W-1:0]  cfg_wr_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [EB_FLAGS_W-1:0]    entry_flags = '0;
    logic [EB_STAMP_W-1:0]    admission_stamp = '0;
    logic [EB_TOKEN_W-1:0]    tokens_routed = '0;
    logic                     is_last = 1'b0;
    logic [EB_CAP_W-1:0]      capacity = '0;
    logic [EB_INCOMING_W-1:0] incoming = '0;
    logic [EB_EPOCH_W-1:0]    request_epoch = '0;
    logic [EB_VERSION_W-1:0]  batch_version = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [EB_STATUS_W-1:0]   status;
    logic [EB_VICTIM_W-1:0]   victim;
    logic                     victim_valid;
    logic [EB_EPOCH_W-1:0]    epoch_echo;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    expert_buffer_victim_select u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .entry_flags     (entry_flags),
        .admission_stamp (admission_stamp),
        .tokens_routed   (tokens_routed),
        .is_last         (is_last),
        .capacity        (capacity),
        .incoming        (incoming),
        .request_epoch   (request_epoch),
        .batch_version   (batch_version),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .victim          (victim),
        .victim_valid    (victim_valid),
        .epoch_echo      (epoch_echo)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    decision_t  decisions_due[$];   // predicted decisions, oldest first
    slot_req_t  batch_q[$];         // batch being assembled for sending
    int         errors = 0;
    int         cycles = 0;
    int         requests_sent = 0;
    int         batches_sent = 0;
    int         decisions_checked = 0;
    int         status_tally[8];
    int         sender_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         stall_left = 0;

    // ------------------------------------------------------------------------
    // Scan model: its own copy of the block's state and register
    // ------------------------------------------------------------------------
    logic [EB_VERSION_W-1:0]  exp_version = EB_VERSION_DEFAULT;
    logic [6:0]               m_index;
    logic [6:0]               m_resident;
    logic [EB_VICTIM_W-1:0]   m_best_idx;
    logic                     m_best_found;
    logic                     m_best_active;
    logic [EB_STAMP_W-1:0]    m_best_stamp;
    logic                     m_err;
    logic [EB_CAP_W-1:0]      m_cap;
    logic [EB_INCOMING_W-1:0] m_inc;
    logic [EB_EPOCH_W-1:0]    m_epoch;
    logic                     m_inc_res;
    logic                     m_inc_act;

    task automatic clear_scan();
        m_index       = '0;
        m_resident    = '0;
        m_best_idx    = '0;
        m_best_found  = 1'b0;
        m_best_active = 1'b1;
        m_best_stamp  = '0;
        m_err         = 1'b0;
        m_cap         = '0;
        m_inc         = '0;
        m_epoch       = '0;
        m_inc_res     = 1'b0;
        m_inc_act     = 1'b0;
    endtask

    // Advance the scan by one accepted entry; queue a decision on the last one
    task automatic predict_slot(input slot_req_t r);
        logic      active;
        decision_t d;
        active = (r.tokens != '0);
        // Request values come from the first entry only
        if (m_index == '0)
        begin
            m_cap   = r.cap;
            m_inc   = r.inc;
            m_epoch = r.epoch;
            if (r.version != exp_version || r.cap == '0 || r.epoch == '0)
                m_err = 1'b1;
        end
        if (m_index >= SLOTS)
        begin
            // Oversized batch: flag it and hold the counter
            m_err = 1'b1;
        end
        else
        begin
            if ((r.flags & ~FLAG_KNOWN) != '0)
                m_err = 1'b1;
            else if (!r.flags[EB_RES_BIT])
            begin
                if (r.flags != '0 || r.stamp != '0)
                    m_err = 1'b1;
            end
            else
            begin
                if (r.stamp == '0)
                    m_err = 1'b1;
                m_resident++;
                // Idle beats active; within a class the later stamp wins,
                // ties keep the earlier slot
                if (r.flags[EB_ELIG_BIT] &&
                    (!m_best_found || (!active && m_best_active) ||
                     (active == m_best_active && r.stamp > m_best_stamp)))
                begin
                    m_best_idx    = m_index[EB_VICTIM_W-1:0];
                    m_best_active = active;
                    m_best_stamp  = r.stamp;
                    m_best_found  = 1'b1;
                end
            end
            if (m_index == m_inc)
            begin
                m_inc_res = r.flags[EB_RES_BIT];
                m_inc_act = active;
            end
            m_index++;
        end

        if (r.last)
        begin
            if (m_cap > m_index || m_inc >= m_index || m_resident > m_cap || !m_inc_act)
                m_err = 1'b1;
            d.status       = ST_INVALID;
            d.victim       = '0;
            d.victim_valid = 1'b0;
            d.epoch        = m_epoch;
            if (!m_err)
            begin
                if (m_inc_res)
                    d.status = ST_HIT;
                else if (m_resident < m_cap)
                    d.status = ST_ADMIT;
                else if (m_best_found)
                begin
                    d.status       = ST_EVICT;
                    d.victim       = m_best_idx;
                    d.victim_valid = 1'b1;
                end
                else
                    d.status = ST_BLOCKED;
            end
            decisions_due.push_back(d);
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random backpressure bursts and the decision checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (rst_n && recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct)
        begin
            // Hold off for a burst of random length
            stall_left <= $urandom_range(0, 13);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    always @(posedge clk)
    begin
        decision_t d;
        if (rst_n && out_valid && out_ready)
        begin
            status_tally[status]++;
            if (decisions_due.size() == 0)
            begin
                errors++;
                $display("%0t: decision with none predicted: status %0d epoch %h",
                         $time, status, epoch_echo);
            end
            else
            begin
                d = decisions_due.pop_front();
                decisions_checked++;
                if (status !== d.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, d.status, status);
                end
                if (victim !== d.victim)
                begin
                    errors++;
                    $display("%0t: victim expected %0d actual %0d",
                             $time, d.victim, victim);
                end
                if (victim_valid !== d.victim_valid)
                begin
                    errors++;
                    $display("%0t: victim_valid expected %0d actual %0d",
                             $time, d.victim_valid, victim_valid);
                end
                if (epoch_echo !== d.epoch)
                begin
                    errors++;
                    $display("%0t: epoch_echo expected %h actual %h",
                             $time, d.epoch, epoch_echo);
                end
            end
        end
    end

    // Watchdog: give up well beyond the slowest legal run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d decisions outstanding",
                     $time, decisions_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    // Send one request and advance the model once it is accepted
    task automatic send_slot(input slot_req_t r);
        int gap;
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        entry_flags     <= r.flags;
        admission_stamp <= r.stamp;
        tokens_routed   <= r.tokens;
        is_last         <= r.last;
        capacity        <= r.cap;
        incoming        <= r.inc;
        request_epoch   <= r.epoch;
        batch_version   <= r.version;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_slot(r);
        requests_sent++;
    endtask

    task automatic run_batch();
        foreach (batch_q[i])
            send_slot(batch_q[i]);
        batch_q.delete();
        batches_sent++;
    endtask

    task automatic add_slot(input logic [7:0] flags, input logic [63:0] stamp,
                            input logic [31:0] tokens, input logic last,
                            input logic [6:0] cap, input logic [5:0] inc,
                            input logic [63:0] epoch, input logic [31:0] version);
        slot_req_t s;
        s.flags   = flags;
        s.stamp   = stamp;
        s.tokens  = tokens;
        s.last    = last;
        s.cap     = cap;
        s.inc     = inc;
        s.epoch   = epoch;
        s.version = version;
        batch_q.push_back(s);
    endtask

    // Drop the request line, drain every decision, then write the register
    task automatic set_expected_version(input logic [31:0] v);
        in_valid <= 1'b0;
        while (decisions_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        exp_version = v;
    endtask

    // Well-formed batch of n slots aimed at one of hit, admit, evict/blocked
    task automatic build_clean_batch(input int n);
        int          cap, inc, mode, target, elig_pct, stamp_style, j;
        logic [63:0] res_map;
        logic [63:0] epoch;
        slot_req_t   s;
        cap   = $urandom_range(1, n);
        inc   = $urandom_range(0, n - 1);
        mode  = $urandom_range(0, 3);
        res_map = '0;
        if (mode == 0)
        begin
            res_map[inc] = 1'b1;
            target = $urandom_range(1, cap);
        end
        else if (mode == 1)
            target = $urandom_range(0, cap - 1);
        else
            target = (cap < n) ? cap : n - 1;
        while ($countones(res_map) < target)
        begin
            j = $urandom_range(0, n - 1);
            if (mode == 0 || j != inc)
                res_map[j] = 1'b1;
        end
        case ($urandom_range(0, 3))
            0:       elig_pct = 0;
            1:       elig_pct = 100;
            default: elig_pct = 50;
        endcase
        stamp_style = $urandom_range(0, 2);
        epoch = rand_word64();
        if (epoch == '0)
            epoch = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            s.flags = '0;
            s.stamp = '0;
            if (res_map[i])
            begin
                s.flags = FLAG_RES;
                if ($urandom_range(0, 99) < elig_pct)
                    s.flags = s.flags | FLAG_ELIG;
                // Narrow stamps force ties, wide ones reach the top bits
                case (stamp_style)
                    0:       s.stamp = 64'($urandom_range(1, 4));
                    1:       s.stamp = rand_word64();
                    default: s.stamp = '1 - 64'($urandom_range(0, 3));
                endcase
                if (s.stamp == '0)
                    s.stamp = 64'd1;
            end
            s.tokens = '0;
            if (i == inc || $urandom_range(0, 1))
            begin
                s.tokens = ($urandom_range(0, 7) == 0) ? '1 : $urandom;
                if (s.tokens == '0)
                    s.tokens = 32'd1;
            end
            s.last = (i == n - 1);
            if (i == 0 || $urandom_range(0, 1))
            begin
                s.cap     = 7'(cap);
                s.inc     = 6'(inc);
                s.epoch   = epoch;
                s.version = exp_version;
            end
            else
            begin
                // Some later slots carry junk request fields, which must be ignored
                s.cap     = 7'($urandom_range(0, 127));
                s.inc     = 6'($urandom_range(0, 63));
                s.epoch   = rand_word64();
                s.version = $urandom;
            end
            batch_q.push_back(s);
        end
    endtask

    // Break a clean batch in one way; the model decides what follows
    task automatic inject_fault(input int n, input int kind);
        int        j, extra;
        slot_req_t s;
        j = $urandom_range(0, n - 1);
        case (kind)
            FLT_VERSION:  batch_q[0].version ^= 32'd1 << $urandom_range(0, 31);
            FLT_EPOCH:    batch_q[0].epoch = '0;
            FLT_ZERO_CAP: batch_q[0].cap = '0;
            FLT_BIG_CAP:  batch_q[0].cap = 7'($urandom_range(n + 1, 127));
            FLT_INCOMING:
                if (n < SLOTS)
                    batch_q[0].inc = 6'($urandom_range(n, 63));
            FLT_BAD_FLAG:
                batch_q[j].flags |= ~FLAG_KNOWN & 8'($urandom_range(4, 255));
            FLT_NONRES:
                if (!batch_q[j].flags[EB_RES_BIT])
                begin
                    if ($urandom_range(0, 1))
                        batch_q[j].flags = FLAG_ELIG;
                    else
                        batch_q[j].stamp = rand_word64() | 64'd1;
                end
            FLT_NO_STAMP:
                if (batch_q[j].flags[EB_RES_BIT])
                    batch_q[j].stamp = '0;
            FLT_OVERFULL:
                foreach (batch_q[i])
                    if (!batch_q[i].flags[EB_RES_BIT])
                    begin
                        batch_q[i].flags = FLAG_RES | FLAG_ELIG;
                        batch_q[i].stamp = rand_word64() | 64'd1;
                    end
            FLT_IDLE_INC:
                if (batch_q[0].inc < n)
                    batch_q[batch_q[0].inc].tokens = '0;
            FLT_OVERSIZE:
            begin
                // Run the batch past the last slot
                batch_q[$].last = 1'b0;
                extra = $urandom_range(SLOTS - n + 1, SLOTS - n + 16);
                for (int i = 0; i < extra; i++)
                begin
                    s = batch_q[0];
                    s.flags  = $urandom_range(0, 1) ? (FLAG_RES | FLAG_ELIG) : 8'd0;
                    s.stamp  = s.flags[EB_RES_BIT] ? (rand_word64() | 64'd1) : 64'd0;
                    s.tokens = $urandom;
                    s.last   = (i == extra - 1);
                    batch_q.push_back(s);
                end
            end
            default:
                foreach (batch_q[i])
                begin
                    batch_q[i].flags   = 8'($urandom_range(0, 255));
                    batch_q[i].stamp   = rand_word64();
                    batch_q[i].tokens  = $urandom;
                    batch_q[i].cap     = 7'($urandom_range(0, 127));
                    batch_q[i].inc     = 6'($urandom_range(0, 63));
                    batch_q[i].epoch   = rand_word64();
                    batch_q[i].version = $urandom_range(0, 1) ? exp_version : $urandom;
                end
        endcase
    endtask

    // Random batches, mostly short, a few at full size, a quarter broken
    task automatic run_random_batches(input int count);
        int start, p, n;
        start = requests_sent;
        while (requests_sent - start < count)
        begin
            p = $urandom_range(0, 99);
            if (p < 70)
                n = $urandom_range(1, 8);
            else if (p < 90)
                n = $urandom_range(9, 32);
            else if (p < 97)
                n = $urandom_range(33, SLOTS - 1);
            else
                n = SLOTS;
            build_clean_batch(n);
            if ($urandom_range(0, 99) < 25)
                inject_fault(n, $urandom_range(FLT_VERSION, FLT_GARBAGE));
            run_batch();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One batch per decision, under the version left by reset
    task automatic test_decisions();
        // hit: incoming slot 1 is resident and active
        add_slot(FLAG_RES | FLAG_ELIG, '1, '0, 1'b0, 7'd2, 6'd1, '1, exp_version);
        add_slot(FLAG_RES, 64'd1, '1, 1'b1, '0, '0, '0, '0);
        run_batch();
        // admit: one resident, room for two
        add_slot('0, '0, 32'd5, 1'b0, 7'd2, 6'd0, 64'd2, exp_version);
        add_slot(FLAG_RES | FLAG_ELIG, 64'd7, '0, 1'b1, 7'd99, 6'd9, '0, '1);
        run_batch();
        // evict: idle slot 1 beats active slot 0 despite its older stamp
        add_slot(FLAG_RES | FLAG_ELIG, 64'd100, 32'd3, 1'b0, 7'd2, 6'd2,
                 64'h8000_0000_0000_0000, exp_version);
        add_slot(FLAG_RES | FLAG_ELIG, 64'd50, '0, 1'b0, '0, '0, '0, '0);
        add_slot('0, '0, 32'd1, 1'b1, '0, '0, '0, '0);
        run_batch();
        // blocked: full, and the only resident slot is not eligible
        add_slot(FLAG_RES, 64'd9, '0, 1'b0, 7'd1, 6'd1, 64'd4, exp_version);
        add_slot('0, '0, 32'd1, 1'b1, '0, '0, '0, '0);
        run_batch();
    endtask

    // One short batch per fault; each must come back invalid
    task automatic test_faults();
        // version mismatch
        add_slot('0, '0, 32'd1, 1'b1, 7'd1, 6'd0, 64'd3, exp_version ^ 32'h8000_0000);
        run_batch();
        // zero epoch
        add_slot('0, '0, 32'd1, 1'b1, 7'd1, 6'd0, '0, exp_version);
        run_batch();
        // zero capacity
        add_slot('0, '0, 32'd1, 1'b1, 7'd0, 6'd0, 64'd5, exp_version);
        run_batch();
        // capacity above the slot count
        add_slot('0, '0, 32'd1, 1'b1, 7'd2, 6'd0, 64'd6, exp_version);
        run_batch();
        // incoming beyond the batch
        add_slot('0, '0, 32'd1, 1'b1, 7'd1, 6'd63, 64'd7, exp_version);
        run_batch();
        // unknown flag bits
        add_slot(8'hFF, 64'd1, 32'd1, 1'b1, 7'd1, 6'd0, 64'd8, exp_version);
        run_batch();
        // nonresident slot with flags set, then one with a stamp
        add_slot(FLAG_ELIG, '0, 32'd1, 1'b0, 7'd1, 6'd0, 64'd9, exp_version);
        add_slot('0, 64'd1, '0, 1'b1, '0, '0, '0, '0);
        run_batch();
        // resident slot with no stamp
        add_slot(FLAG_RES, '0, 32'd1, 1'b1, 7'd1, 6'd0, 64'd10, exp_version);
        run_batch();
        // more residents than capacity
        add_slot(FLAG_RES, 64'd1, 32'd1, 1'b0, 7'd1, 6'd0, 64'd11, exp_version);
        add_slot(FLAG_RES, 64'd2, 32'd1, 1'b1, '0, '0, '0, '0);
        run_batch();
        // incoming slot is idle
        add_slot('0, '0, '0, 1'b1, 7'd1, 6'd0, 64'd12, exp_version);
        run_batch();
    endtask

    // Random traffic under several register settings, extremes included
    task automatic test_version_sweep();
        logic [31:0] versions[5];
        versions[0] = '1;
        versions[1] = '0;
        versions[2] = $urandom;
        versions[3] = $urandom;
        versions[4] = EB_VERSION_DEFAULT;
        foreach (versions[k])
        begin
            // Vary the pressure per phase; one phase runs clean
            sender_idle_pct = (k == 3) ? 0 : $urandom_range(5, 30);
            recv_stall_pct  = (k == 3) ? 0 : $urandom_range(5, 30);
            set_expected_version(versions[k]);
            run_random_batches(240);
        end
    endtask

    // Closing stretch at full rate with no idling on either side
    task automatic test_steady_stream();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        set_expected_version($urandom);
        run_random_batches(180);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_scan();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 20;
        recv_stall_pct  = 20;
        test_decisions();
        test_faults();
        test_version_sweep();
        test_steady_stream();

        // Drain what is left, then allow the pipeline to settle
        in_valid <= 1'b0;
        while (decisions_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests in %0d batches; %0d decisions checked.",
                 requests_sent, batches_sent, decisions_checked);
        $display("Decisions seen: invalid %0d, hit %0d, admit %0d, evict %0d, blocked %0d.",
                 status_tally[ST_INVALID], status_tally[ST_HIT], status_tally[ST_ADMIT],
                 status_tally[ST_EVICT], status_tally[ST_BLOCKED]);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
